// ----- hdl/ruc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row union closure package
// Shared widths, the sequencer state type and the list memory write port.
// ----------------------------------------------------------------------------
package ruc_pkg;

   localparam int ROW_W        = 6;
   localparam int ENTRY_W      = 2 * ROW_W;
   localparam int IDX_W        = 6;
   localparam int LIST_DEPTH   = 64;
   localparam int SIZE_W       = 3;
   localparam int MAX_SIZE_DEF = 6;
   localparam int DATA_W       = 16;

   // The list stops growing one short of its depth, so its length fits in IDX_W bits.
   localparam logic [IDX_W-1:0] LIST_LIMIT = IDX_W'(LIST_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_Q_READ,
      ST_Q_TAKE,
      ST_J_READ,
      ST_J_APPEND,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [ENTRY_W-1:0] data;
   } ram_wr_type;

endpackage

// ----- hdl/ruc_list_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row union closure list memory
// One write port and one read port with registered read data; each word
// holds a row union in the low bits and its companion in the high bits.
// ----------------------------------------------------------------------------
module ruc_list_ram (
   input  logic                         clock,
   input  ruc_pkg::ram_wr_type          wr,
   input  logic [ruc_pkg::IDX_W-1:0]    rd_addr,
   output logic [ruc_pkg::ENTRY_W-1:0]  rd_data
);

   logic [ruc_pkg::ENTRY_W-1:0] mem_ff [ruc_pkg::LIST_DEPTH];
   logic [ruc_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/row_union_closure.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row union closure
// Loads a job of row pairs, builds the closure of the rows under OR and
// streams the distinct unions with their companion unions.
// ----------------------------------------------------------------------------
// A job is matrix_size requests, each a row bitmask and its companion row.
// Every request except the last of a job is taken while the block stays
// idle and produces no response. The last request starts the closure: the
// block drops ready and, for each of the first base-1 list entries (base
// being the list length once loading ends), ORs that entry into every entry
// of the list so far, appending each union whose x row it has not yet seen.
// Reading each outer entry and every inner OR-and-append step happen one
// after another, because all list accesses share the single read port of
// the list memory and one append unit. The outer steps end with one closing
// read; with the default maximum size, at most five loaded rows act as outer
// operands. The list is then sent out in the order it was built, each
// response read, loaded and held until rsp_tready takes it before the next
// is read, and a final all-zero response marked with rsp_tlast ends the
// job. Writing the size register restarts the job being loaded; csr_ready
// is always high, but the register should only be written while the block
// is idle.
// ----------------------------------------------------------------------------
module row_union_closure #(
   parameter int MAX_SIZE = ruc_pkg::MAX_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request: [5:0] x_row, [11:6] y_row, [15:12] zero.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ruc_pkg::DATA_W-1:0]  req_tdata,
   // Response: [5:0] x_union, [11:6] y_union, [15:12] zero.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ruc_pkg::DATA_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   // Size register write: [2:0] matrix_size.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ruc_pkg::SIZE_W-1:0]  csr_data
);

   localparam int ROW_W   = ruc_pkg::ROW_W;
   localparam int IDX_W   = ruc_pkg::IDX_W;
   localparam int SIZE_W  = ruc_pkg::SIZE_W;
   localparam int ENTRY_W = ruc_pkg::ENTRY_W;
   localparam logic [SIZE_W-1:0] MAX_SIZE_C = SIZE_W'(MAX_SIZE);

   ruc_pkg::state_type state_ff, state_in;

   logic [SIZE_W-1:0]           size_ff, size_in;
   logic [SIZE_W-1:0]           rows_ff, rows_in;
   logic [IDX_W-1:0]            count_ff, count_in;
   logic [ruc_pkg::LIST_DEPTH-1:0] seen_ff, seen_in;
   logic [IDX_W-1:0]            base_ff, base_in;
   logic [IDX_W-1:0]            i_ff, i_in;
   logic [IDX_W-1:0]            j_ff, j_in;
   logic [IDX_W-1:0]            cnt_ff, cnt_in;
   logic [ENTRY_W-1:0]          q_ff, q_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_fire, rsp_fire, csr_fire;
   logic [SIZE_W-1:0]           size_eff;
   logic                        job_done;
   logic                        q_more;
   logic                        j_last;

   // Append unit shared by loading and closure.
   logic                        app_en, app_ok;
   logic [ROW_W-1:0]            app_x, app_y;
   logic [ruc_pkg::LIST_DEPTH-1:0] seen_base;
   logic [IDX_W-1:0]            count_base;

   ruc_pkg::ram_wr_type         ram_wr;
   logic [IDX_W-1:0]            ram_rd_addr;
   logic [ENTRY_W-1:0]          ram_rd_data;

   ruc_list_ram u_list (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ruc_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign csr_fire   = csr_valid & csr_ready;

   // A size of zero acts as one; anything above the maximum is clamped.
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (size_ff > MAX_SIZE_C) begin
         size_eff = MAX_SIZE_C;
      end else begin
         size_eff = size_ff;
      end
   end

   assign job_done = ((rows_ff + SIZE_W'(1)) >= size_eff);
   assign q_more   = (({1'b0, i_ff} + (IDX_W + 1)'(1)) < {1'b0, base_ff});
   assign j_last   = ((j_ff + IDX_W'(1)) == cnt_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ruc_pkg::ST_IDLE: begin
            if (req_fire && job_done && !csr_fire) begin
               state_in = ruc_pkg::ST_Q_READ;
            end
         end
         ruc_pkg::ST_Q_READ: begin
            state_in = q_more ? ruc_pkg::ST_Q_TAKE : ruc_pkg::ST_EMIT_READ;
         end
         ruc_pkg::ST_Q_TAKE:   state_in = ruc_pkg::ST_J_READ;
         ruc_pkg::ST_J_READ:   state_in = ruc_pkg::ST_J_APPEND;
         ruc_pkg::ST_J_APPEND: begin
            state_in = j_last ? ruc_pkg::ST_Q_READ : ruc_pkg::ST_J_READ;
         end
         ruc_pkg::ST_EMIT_READ: begin
            state_in = (j_ff == count_ff) ? ruc_pkg::ST_EMIT_WAIT : ruc_pkg::ST_EMIT_LOAD;
         end
         ruc_pkg::ST_EMIT_LOAD: state_in = ruc_pkg::ST_EMIT_WAIT;
         ruc_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               state_in = rsp_last_ff ? ruc_pkg::ST_IDLE : ruc_pkg::ST_EMIT_READ;
            end
         end
         default: state_in = ruc_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      size_in      = size_ff;
      rows_in      = rows_ff;
      base_in      = base_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_rd_addr  = j_ff;
      app_en       = 1'b0;
      app_x        = req_tdata[ROW_W-1:0];
      app_y        = req_tdata[ENTRY_W-1:ROW_W];
      seen_base    = seen_ff;
      count_base   = count_ff;

      unique case (state_ff)
         ruc_pkg::ST_IDLE: begin
            if (req_fire) begin
               // The first row of a job starts from an empty list.
               if (rows_ff == '0) begin
                  seen_base  = '0;
                  count_base = '0;
               end
               app_en  = 1'b1;
               rows_in = job_done ? '0 : (rows_ff + SIZE_W'(1));
               i_in    = '0;
            end
         end
         ruc_pkg::ST_Q_READ: begin
            ram_rd_addr = i_ff;
            j_in        = '0;
         end
         ruc_pkg::ST_Q_TAKE: begin
            q_in   = ram_rd_data;
            cnt_in = count_ff;
            j_in   = '0;
         end
         ruc_pkg::ST_J_READ: begin
            ram_rd_addr = j_ff;
         end
         ruc_pkg::ST_J_APPEND: begin
            app_en = 1'b1;
            app_x  = ram_rd_data[ROW_W-1:0] | q_ff[ROW_W-1:0];
            app_y  = ram_rd_data[ENTRY_W-1:ROW_W] | q_ff[ENTRY_W-1:ROW_W];
            j_in   = j_ff + IDX_W'(1);
            if (j_last) begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ruc_pkg::ST_EMIT_READ: begin
            ram_rd_addr = j_ff;
            if (j_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ruc_pkg::ST_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ram_rd_data;
            rsp_last_in  = 1'b0;
         end
         ruc_pkg::ST_EMIT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               rsp_last_in  = 1'b0;
               j_in         = j_ff + IDX_W'(1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      // A union is appended only if new and while the list has room.
      app_ok = app_en && !seen_base[app_x] && (count_base != ruc_pkg::LIST_LIMIT);

      ram_wr.en   = app_ok;
      ram_wr.addr = count_base;
      ram_wr.data = {app_y, app_x};

      seen_in  = seen_base;
      count_in = count_base;
      if (app_ok) begin
         seen_in[app_x] = 1'b1;
         count_in       = count_base + IDX_W'(1);
      end

      // The closure takes outer operands only from the entries present when loading ended.
      if (state_ff == ruc_pkg::ST_IDLE) begin
         base_in = count_in;
      end

      if (csr_fire) begin
         size_in = csr_data;
         rows_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ruc_pkg::ST_IDLE;
         size_ff      <= SIZE_W'(1);
         rows_ff      <= '0;
         count_ff     <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rows_ff      <= rows_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      cnt_ff      <= cnt_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(ruc_pkg::DATA_W - ENTRY_W)'(0), rsp_data_ff};

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row union closure testbench
// Drives jobs of row pairs into row_union_closure and checks every streamed
// union against a behavioral closure predictor. Directed jobs come first, then
// several hundred random rows, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int IDLE_PCT   = 12;
   localparam int RAND_ROWS  = 400;
   localparam int SETTLE     = 12;
   // The largest closure runs with no handshake at all; this limit is meant to
   // leave a wide margin over it.
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [ruc_pkg::ROW_W-1:0] x;
      logic [ruc_pkg::ROW_W-1:0] y;
      logic                      last;
   } union_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [ruc_pkg::DATA_W-1:0]   req_tdata;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [ruc_pkg::DATA_W-1:0]   rsp_tdata;
   logic                         rsp_tlast;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [ruc_pkg::SIZE_W-1:0]   csr_data;

   // Unions the block still owes us, oldest first.
   union_type                    union_q[$];
   int                           errors = 0;
   int                           quiet_cycles = 0;
   bit                           steady = 1'b0;

   // Predictor state: the list being built, the seen map and the job counters.
   logic [ruc_pkg::ROW_W-1:0]    x_tab[ruc_pkg::LIST_DEPTH];
   logic [ruc_pkg::ROW_W-1:0]    y_tab[ruc_pkg::LIST_DEPTH];
   bit                           seen[ruc_pkg::LIST_DEPTH];
   int                           rows_in = 0;
   int                           n_ent = 0;
   logic [ruc_pkg::SIZE_W-1:0]   size_reg = ruc_pkg::SIZE_W'(1);

   row_union_closure dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [5:0] x_row, [11:6] y_row, [15:12] zero
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [5:0] x_union, [11:6] y_union, [15:12] zero
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)     // [2:0] matrix_size
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sizes of zero act as one and sizes past the maximum are clamped.
   function automatic int job_rows(logic [ruc_pkg::SIZE_W-1:0] sz);
      if (sz == 0) return 1;
      if (int'(sz) > ruc_pkg::MAX_SIZE_DEF) return ruc_pkg::MAX_SIZE_DEF;
      return int'(sz);
   endfunction

   // Appends a union unless its row was already seen or the list is full.
   function automatic void add_union(logic [ruc_pkg::ROW_W-1:0] x,
                                     logic [ruc_pkg::ROW_W-1:0] y);
      if (seen[x] || n_ent >= ruc_pkg::LIST_DEPTH - 1) return;
      seen[x]      = 1'b1;
      x_tab[n_ent] = x;
      y_tab[n_ent] = y;
      n_ent++;
   endfunction

   // Updates the predictor for one accepted request. The last row of a job
   // runs the closure and queues the whole list plus the closing entry.
   function automatic void predict_row(logic [ruc_pkg::ROW_W-1:0] x,
                                       logic [ruc_pkg::ROW_W-1:0] y);
      int base;
      int cnt;
      logic [ruc_pkg::ROW_W-1:0] qx;
      logic [ruc_pkg::ROW_W-1:0] qy;
      if (rows_in == 0) begin
         foreach (seen[i]) seen[i] = 1'b0;
         n_ent = 0;
      end
      add_union(x, y);
      rows_in++;
      if (rows_in < job_rows(size_reg)) return;
      rows_in = 0;
      base = n_ent;
      // Only the first base-1 rows act as outer operands; the inner walk
      // covers the list as it stood when the outer step began.
      for (int i = 0; i + 1 < base; i++) begin
         qx  = x_tab[i];
         qy  = y_tab[i];
         cnt = n_ent;
         for (int j = 0; j < cnt; j++) add_union(x_tab[j] | qx, y_tab[j] | qy);
      end
      for (int k = 0; k < n_ent; k++) union_q.push_back('{x_tab[k], y_tab[k], 1'b0});
      union_q.push_back('{'0, '0, 1'b1});
   endfunction

   // Sends one request. The valid is left high on return so that the next
   // request can follow back to back; drain_all lowers it.
   task automatic send_row(logic [ruc_pkg::ROW_W-1:0] x, logic [ruc_pkg::ROW_W-1:0] y);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_row(x, y);
   endtask

   // Holds the sender off until every owed union has arrived and the block
   // has had time to settle back to idle.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (union_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Size writes happen only with the block idle; a write also restarts the
   // job being loaded.
   task automatic write_size(logic [ruc_pkg::SIZE_W-1:0] sz);
      drain_all();
      csr_valid <= 1'b1;
      csr_data  <= sz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_reg = sz;
      rows_in  = 0;
   endtask

   // Size after reset is one, so each request is a whole job. Covers the
   // zero row and the all-ones row.
   task automatic test_reset_size();
      send_row(6'd0, 6'd0);
      send_row(6'h3F, 6'h3F);
   endtask

   // Repeated rows, including repeated zero rows, are dropped from the list.
   task automatic test_repeat_rows();
      write_size(3'd3);
      send_row(6'd5, 6'd9);
      send_row(6'd5, 6'd1);
      send_row(6'd10, 6'd2);
      write_size(3'd2);
      send_row(6'd0, 6'd7);
      send_row(6'd0, 6'd56);
   endtask

   // Out-of-range sizes, the full 63-entry list and row bits above the size.
   task automatic test_size_bounds();
      write_size(3'd0);
      send_row(6'd42, 6'd21);
      write_size(3'd7);
      for (int b = 0; b < ruc_pkg::ROW_W; b++) send_row(6'(1 << b), 6'(32 >> b));
      write_size(3'd2);
      send_row(6'd48, 6'd3);
      send_row(6'd3, 6'd48);
   endtask

   // A size write in the middle of loading throws the partial job away.
   task automatic test_restart();
      write_size(3'd4);
      send_row(6'd7, 6'd0);
      send_row(6'd9, 6'd1);
      write_size(3'd2);
      send_row(6'd17, 6'd34);
      send_row(6'd6, 6'd12);
   endtask

   // Random jobs. Most rows stay within the job width and some repeat an
   // earlier row of the job; a few jobs are cut short by a size write.
   task automatic test_random_jobs();
      int sent;
      int phase;
      int n;
      int want;
      logic [ruc_pkg::SIZE_W-1:0] sz;
      logic [ruc_pkg::ROW_W-1:0]  mask;
      logic [ruc_pkg::ROW_W-1:0]  x;
      logic [ruc_pkg::ROW_W-1:0]  job_x[$];
      sent  = 0;
      phase = 0;
      while (sent < RAND_ROWS) begin
         sz = ruc_pkg::SIZE_W'($urandom_range(7));
         // The phase with no idling uses full-size jobs for a long stretch.
         if (phase == 2) sz = ruc_pkg::SIZE_W'(ruc_pkg::MAX_SIZE_DEF);
         write_size(sz);
         // One phase runs with neither side ever idling.
         steady = (phase == 2);
         n    = job_rows(sz);
         mask = ruc_pkg::ROW_W'((1 << n) - 1);
         for (int j = $urandom_range(1, 6); j > 0; j--) begin
            want = n;
            if (!steady && $urandom_range(9) == 0) want = $urandom_range(n) - 1;
            job_x.delete();
            for (int r = 0; r < want; r++) begin
               if (job_x.size() != 0 && $urandom_range(4) == 0)
                  x = job_x[$urandom_range(job_x.size() - 1)];
               else if ($urandom_range(9) < 8)
                  x = ruc_pkg::ROW_W'($urandom) & mask;
               else
                  x = ruc_pkg::ROW_W'($urandom);
               job_x.push_back(x);
               send_row(x, ruc_pkg::ROW_W'($urandom));
               sent++;
            end
            if (want < n) break;
         end
         steady = 1'b0;
         phase++;
      end
   endtask

   // Response side: random stalls on tready, and each accepted response is
   // checked against the oldest owed union.
   always @(posedge clock) begin
      union_type exp_u;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            if (union_q.size() == 0) begin
               $display("%0t: unexpected response, got x=%h y=%h last=%b", $realtime,
                        rsp_tdata[5:0], rsp_tdata[11:6], rsp_tlast);
               errors++;
            end else begin
               exp_u = union_q.pop_front();
               if (rsp_tdata[5:0] !== exp_u.x) begin
                  $display("%0t: x_union mismatch, expected %h, actual %h", $realtime,
                           exp_u.x, rsp_tdata[5:0]);
                  errors++;
               end
               if (rsp_tdata[11:6] !== exp_u.y) begin
                  $display("%0t: y_union mismatch, expected %h, actual %h", $realtime,
                           exp_u.y, rsp_tdata[11:6]);
                  errors++;
               end
               if (rsp_tlast !== exp_u.last) begin
                  $display("%0t: last_entry mismatch, expected %b, actual %b", $realtime,
                           exp_u.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_size();
      test_repeat_rows();
      test_size_bounds();
      test_restart();
      test_random_jobs();
      drain_all();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/ruc_pkg.sv
hdl/ruc_list_ram.sv
hdl/row_union_closure.sv
dv/tb_top.sv
